### src/bgs_pkg.sv
package bgs_pkg;

  localparam int ValW  = 24;
  localparam int CoefW = 32;
  localparam int ColW  = 6;
  localparam int RowW  = 12;
  localparam int CfgW  = 32;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAdvX   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAdvY   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDiffX  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDiffY  = 3'd5;

  typedef logic signed [ValW-1:0] val_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_PROD  = 5'b00100,
    S_COEF  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic prod;
    logic coef;
    logic sum;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic out_busy;
  } sts_t;

  function automatic logic signed [47:0] rnd_shift(input logic signed [79:0] v,
                                                    input int s);
    logic signed [79:0] b;
    begin
      b = v + (80'sd1 <<< (s - 1));
      rnd_shift = 48'(b >>> s);
    end
  endfunction

endpackage

### src/bgs_ram.sv
module bgs_ram #(
  parameter int Width = 24,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### src/bgs_ctrl.sv
module bgs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  bgs_pkg::sts_t sts,
  output bgs_pkg::cmd_t cmd
);
  import bgs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_stall = (state != S_IDLE) || sts.out_busy;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !sts.out_busy) begin
          cmd.load = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_next = sts.emit ? S_PROD : S_IDLE;
      end
      S_PROD: begin
        cmd.prod = 1'b1;
        state_next = S_COEF;
      end
      S_COEF: begin
        cmd.coef = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.sum = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

### src/bgs_dp.sv
module bgs_dp #(
  parameter int MaxWidth = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bgs_pkg::cmd_t              cmd,
  output bgs_pkg::sts_t              sts,
  input  logic                       cfg_we,
  input  logic [bgs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bgs_pkg::CfgW-1:0]   cfg_data,
  input  logic [bgs_pkg::ValW-1:0]   u_in,
  input  logic [bgs_pkg::ValW-1:0]   v_in,
  input  logic                       grid_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bgs_pkg::ValW-1:0]   u_out,
  output logic [bgs_pkg::ValW-1:0]   v_out,
  output logic [bgs_pkg::ColW-1:0]   col_index,
  output logic [bgs_pkg::RowW-1:0]   row_index,
  output logic                       last
);
  import bgs_pkg::*;

  localparam int XW = $clog2(MaxWidth + 1);
  localparam int AW = $clog2(MaxWidth) + 1;

  logic [6:0]  grid_width;
  logic [12:0] grid_height;
  logic [CoefW-1:0] adv_x, adv_y, dif_x, dif_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 7'd41;
      grid_height <= 13'd41;
      adv_x <= 32'd75497;
      adv_y <= 32'd75497;
      dif_x <= 32'd15099;
      dif_y <= 32'd15099;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegWidth:  grid_width  <= cfg_data[6:0];
        RegHeight: grid_height <= cfg_data[12:0];
        RegAdvX:   adv_x <= cfg_data;
        RegAdvY:   adv_y <= cfg_data;
        RegDiffX:  dif_x <= cfg_data;
        RegDiffY:  dif_y <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [XW-1:0] wlim;
  logic [12:0]   hlim;
  always_comb begin
    if (grid_width < 7'd3) wlim = XW'(3);
    else if (32'(grid_width) > MaxWidth) wlim = XW'(MaxWidth);
    else wlim = XW'(grid_width);
    if (grid_height < 13'd3) hlim = 13'd3;
    else if (grid_height > 13'd4096) hlim = 13'd4096;
    else hlim = grid_height;
  end

  logic [XW-1:0] col_cnt;
  logic [RowW-1:0] row_cnt;
  logic [XW-1:0] x0, x1;
  logic [12:0] y0, y1, yn;
  always_comb begin
    x0 = grid_start ? '0 : col_cnt;
    y0 = grid_start ? '0 : 13'(row_cnt);
    if (x0 >= wlim) begin
      x0 = '0;
      y0 = y0 + 13'd1;
    end
    if (y0 >= hlim) y0 = '0;
    x1 = x0 + XW'(1);
    yn = y0;
    if (x1 >= wlim) begin
      x1 = '0;
      yn = y0 + 13'd1;
      if (yn >= hlim) yn = '0;
    end
    y1 = yn;
  end

  logic [XW-1:0] px;
  logic [12:0]   py;
  logic          plast;
  val_t          pu, pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (cmd.load) begin
      col_cnt <= x1;
      row_cnt <= y1[RowW-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= x0;
      py <= y0;
      plast <= (x0 == wlim - XW'(1)) && (y0 == hlim - 13'd1);
      pu <= val_t'(u_in);
      pv <= val_t'(v_in);
    end
  end

  logic [AW-1:0] ti_a, mi_a;
  assign ti_a = {y0[0], (AW-1)'(x0)};
  assign mi_a = {~y0[0], (AW-1)'(x0)};

  logic [2*ValW-1:0] top_d, mid_d;
  logic [AW-1:0] ti_q;
  always_ff @(posedge clk) if (cmd.load) ti_q <= ti_a;

  bgs_ram #(.Width(2*ValW), .Depth(2**AW)) u_top (
    .clk(clk), .we(cmd.rd), .waddr(ti_q), .wdata({pu, pv}),
    .raddr(ti_a), .rdata(top_d));
  bgs_ram #(.Width(2*ValW), .Depth(2**AW)) u_mid (
    .clk(clk), .we(cmd.rd), .waddr(ti_q), .wdata({pu, pv}),
    .raddr(mi_a), .rdata(mid_d));

  val_t wu [6];
  val_t wv [6];
  val_t cu, cv, lu, lv, ru, rv, uu, uv, du, dv;

  assign sts.emit = (px >= XW'(2)) && (py >= 13'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        wu[i] <= '0;
        wv[i] <= '0;
      end
    end else if (cmd.rd) begin
      cu <= wu[2]; cv <= wv[2];
      lu <= wu[3]; lv <= wv[3];
      ru <= val_t'(mid_d[2*ValW-1:ValW]); rv <= val_t'(mid_d[ValW-1:0]);
      uu <= wu[0]; uv <= wv[0];
      du <= wu[4]; dv <= wv[4];
      wu[1] <= wu[0]; wu[0] <= val_t'(top_d[2*ValW-1:ValW]);
      wu[3] <= wu[2]; wu[2] <= val_t'(mid_d[2*ValW-1:ValW]);
      wu[5] <= wu[4]; wu[4] <= pu;
      wv[1] <= wv[0]; wv[0] <= val_t'(top_d[ValW-1:0]);
      wv[3] <= wv[2]; wv[2] <= val_t'(mid_d[ValW-1:0]);
      wv[5] <= wv[4]; wv[4] <= pv;
    end
  end

  // stage 1: advection products rounded to Q.16, laplacians
  logic signed [33:0] pau, pbu, pav, pbv;
  logic signed [26:0] lxu, lyu, lxv, lyv;
  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      pau <= 34'(rnd_shift(80'(cu * (25'(cu) - 25'(lu))), 16));
      pbu <= 34'(rnd_shift(80'(cv * (25'(cu) - 25'(uu))), 16));
      pav <= 34'(rnd_shift(80'(cu * (25'(cv) - 25'(lv))), 16));
      pbv <= 34'(rnd_shift(80'(cv * (25'(cv) - 25'(uv))), 16));
      lxu <= 27'(ru) - (27'(cu) <<< 1) + 27'(lu);
      lyu <= 27'(du) - (27'(cu) <<< 1) + 27'(uu);
      lxv <= 27'(rv) - (27'(cv) <<< 1) + 27'(lv);
      lyv <= 27'(dv) - (27'(cv) <<< 1) + 27'(uv);
    end
  end

  // stage 2: coefficient products rounded to Q.16
  logic signed [47:0] t [8];
  always_ff @(posedge clk) begin
    if (cmd.coef) begin
      t[0] <= rnd_shift(80'(pau * $signed({1'b0, adv_x})), 24);
      t[1] <= rnd_shift(80'(pbu * $signed({1'b0, adv_y})), 24);
      t[2] <= rnd_shift(80'(lxu * $signed({1'b0, dif_x})), 24);
      t[3] <= rnd_shift(80'(lyu * $signed({1'b0, dif_y})), 24);
      t[4] <= rnd_shift(80'(pav * $signed({1'b0, adv_x})), 24);
      t[5] <= rnd_shift(80'(pbv * $signed({1'b0, adv_y})), 24);
      t[6] <= rnd_shift(80'(lxv * $signed({1'b0, dif_x})), 24);
      t[7] <= rnd_shift(80'(lyv * $signed({1'b0, dif_y})), 24);
    end
  end

  logic signed [51:0] su, sv;
  assign su = 52'(cu) - 52'(t[0]) - 52'(t[1]) + 52'(t[2]) + 52'(t[3]);
  assign sv = 52'(cv) - 52'(t[4]) - 52'(t[5]) + 52'(t[6]) + 52'(t[7]);

  function automatic logic [ValW-1:0] sat(input logic signed [51:0] s);
    if (s > 52'sd8388607) sat = 24'h7FFFFF;
    else if (s < -52'sd8388608) sat = 24'h800000;
    else sat = s[ValW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.sum) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      u_out <= sat(su);
      v_out <= sat(sv);
      col_index <= ColW'(px - XW'(1));
      row_index <= RowW'(py - 13'd1);
      last <= plast;
    end
  end

  assign sts.out_busy = out_valid && out_stall;
endmodule

### src/burgers_2d_stencil_step_top.sv
// Burgers 2D stencil step: one explicit time step, points in raster order.
// Input channel: u_in, v_in, grid_start with in_valid / in_stall.
// Output channel: u_out, v_out, col_index, row_index, last with
// out_valid / out_stall. Point (x,y) with x,y >= 2 yields interior point
// (x-1,y-1); other points yield nothing.
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// An item that yields no result passes only the line store read; one that
// does is stepped by the sequencer through line store read, advection product,
// coefficient product and sum/saturate, which writes the output register.
// A new item is accepted only once the sequencer is back in idle.
// A waiting result stays registered; the next item is accepted only once
// the output register is free, so a stalled receiver stalls the input.
// Reset restores register defaults, clears the window and position; the
// line stores are not cleared and are filled by the first rows of a grid.
module burgers_2d_stencil_step_top #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bgs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bgs_pkg::CfgW-1:0]     cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bgs_pkg::ValW-1:0]     u_in,
  input  logic [bgs_pkg::ValW-1:0]     v_in,
  input  logic                         grid_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bgs_pkg::ValW-1:0]     u_out,
  output logic [bgs_pkg::ValW-1:0]     v_out,
  output logic [bgs_pkg::ColW-1:0]     col_index,
  output logic [bgs_pkg::RowW-1:0]     row_index,
  output logic                         last
);
  import bgs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bgs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd));

  bgs_dp #(.MaxWidth(MAX_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .u_in(u_in), .v_in(v_in), .grid_start(grid_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .u_out(u_out), .v_out(v_out), .col_index(col_index),
    .row_index(row_index), .last(last));
endmodule

### src/bgs_chk.sv
module bgs_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [5:0] col_index
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");
  a_one_per_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("back to back accept");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> col_index != 6'd0)
    else $error("boundary column emitted");
endmodule

bind burgers_2d_stencil_step_top bgs_chk u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .col_index(col_index));

### test/burgers_2d_stencil_step_top_test.sv
`timescale 1ns / 1ps

module burgers_2d_stencil_step_top_test;
  import bgs_pkg::*;

  localparam int MaxW = 64;
  localparam int MaxH = 4096;
  localparam int ValMax = 8388607;
  localparam int ValMin = -8388608;
  localparam longint CycleLimit = 3000000;

  typedef struct {
    logic [ValW-1:0] u;
    logic [ValW-1:0] v;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            last;
  } point_t;

  logic clk, rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [ValW-1:0] u_in, v_in;
  logic grid_start;
  logic out_valid, out_stall;
  logic [ValW-1:0] u_out, v_out;
  logic [ColW-1:0] col_index;
  logic [RowW-1:0] row_index;
  logic last;

  burgers_2d_stencil_step_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .u_in(u_in), .v_in(v_in), .grid_start(grid_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .u_out(u_out), .v_out(v_out), .col_index(col_index),
    .row_index(row_index), .last(last)
  );

  // stencil model state
  logic [6:0]  m_width;
  logic [12:0] m_height;
  logic [31:0] m_adv_x, m_adv_y, m_diff_x, m_diff_y;
  int lines_u [2*MaxW];
  int lines_v [2*MaxW];
  int win_u [6];
  int win_v [6];
  int pos_x, pos_y;

  point_t updates_q [$];
  int errors = 0;
  int items_sent = 0;
  bit calm = 0;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint rnd_q(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint scale(longint q, logic [31:0] c);
    return rnd_q(q * longint'(c), 24);
  endfunction

  function automatic int stencil(int c, int l, int r, int up, int dn, int uc, int vc);
    longint pa, pb, lx, ly, s;
    pa = rnd_q(longint'(uc) * (longint'(c) - l), 16);
    pb = rnd_q(longint'(vc) * (longint'(c) - up), 16);
    lx = longint'(r) - 2 * longint'(c) + l;
    ly = longint'(dn) - 2 * longint'(c) + up;
    s = longint'(c) - scale(pa, m_adv_x) - scale(pb, m_adv_y)
        + scale(lx, m_diff_x) + scale(ly, m_diff_y);
    if (s > ValMax) s = ValMax;
    if (s < ValMin) s = ValMin;
    return int'(s);
  endfunction

  task automatic model_reset();
    m_width = 41; m_height = 41;
    m_adv_x = 75497; m_adv_y = 75497; m_diff_x = 15099; m_diff_y = 15099;
    foreach (lines_u[i]) begin lines_u[i] = 0; lines_v[i] = 0; end
    foreach (win_u[i]) begin win_u[i] = 0; win_v[i] = 0; end
    pos_x = 0; pos_y = 0;
  endtask

  function automatic int eff_width();
    return (m_width < 3) ? 3 : (m_width > MaxW) ? MaxW : int'(m_width);
  endfunction

  function automatic int eff_height();
    return (m_height < 3) ? 3 : (m_height > MaxH) ? MaxH : int'(m_height);
  endfunction

  task automatic model_point(int uin, int vin, bit gs);
    int w, h, x, y, ti, mi, tu, tv, mu, mv;
    point_t p;
    w = eff_width();
    h = eff_height();
    x = pos_x; y = pos_y;
    if (gs) begin x = 0; y = 0; end
    if (x >= w) begin x = 0; y++; end
    if (y >= h) y = 0;
    ti = (y & 1) * MaxW + x;
    mi = ((y + 1) & 1) * MaxW + x;
    tu = lines_u[ti]; tv = lines_v[ti];
    mu = lines_u[mi]; mv = lines_v[mi];
    if (x >= 2 && y >= 2) begin
      p.u = ValW'(stencil(win_u[2], win_u[3], mu, win_u[0], win_u[4], win_u[2], win_v[2]));
      p.v = ValW'(stencil(win_v[2], win_v[3], mv, win_v[0], win_v[4], win_u[2], win_v[2]));
      p.col = ColW'(x - 1);
      p.row = RowW'(y - 1);
      p.last = (x == w - 1 && y == h - 1);
      updates_q.push_back(p);
    end
    win_u[1] = win_u[0]; win_u[0] = tu; win_u[3] = win_u[2]; win_u[2] = mu;
    win_u[5] = win_u[4]; win_u[4] = uin;
    win_v[1] = win_v[0]; win_v[0] = tv; win_v[3] = win_v[2]; win_v[2] = mv;
    win_v[5] = win_v[4]; win_v[4] = vin;
    lines_u[ti] = uin; lines_v[ti] = vin;
    x++;
    if (x >= w) begin
      x = 0; y++;
      if (y >= h) y = 0;
    end
    pos_x = x & 8'h7f;
    pos_y = y & 12'hfff;
  endtask

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: alternating stall and run stretches
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    point_t e;
    if (!rst && out_valid && !out_stall) begin
      if (updates_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected update col %0d row %0d", $time, col_index, row_index);
      end else begin
        e = updates_q.pop_front();
        if (u_out !== e.u || v_out !== e.v || col_index !== e.col ||
            row_index !== e.row || last !== e.last) begin
          errors++;
          $display("%0t: mismatch exp u %h v %h col %0d row %0d last %b",
                   $time, e.u, e.v, e.col, e.row, e.last);
          $display("%0t:          got u %h v %h col %0d row %0d last %b",
                   $time, u_out, v_out, col_index, row_index, last);
        end
      end
    end
  end

  task automatic send_point(int uin, int vin, bit gs);
    int g;
    u_in <= ValW'(uin);
    v_in <= ValW'(vin);
    grid_start <= gs;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_point(uin, vin, gs);
    items_sent++;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (updates_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegWidth:  m_width = val[6:0];
      RegHeight: m_height = val[12:0];
      RegAdvX:   m_adv_x = val;
      RegAdvY:   m_adv_y = val;
      RegDiffX:  m_diff_x = val;
      RegDiffY:  m_diff_y = val;
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [31:0] w, logic [31:0] h, logic [31:0] ax,
                          logic [31:0] ay, logic [31:0] dx, logic [31:0] dy);
    drain();
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegAdvX, ax);
    write_reg(RegAdvY, ay);
    write_reg(RegDiffX, dx);
    write_reg(RegDiffY, dy);
  endtask

  function automatic int rand_val(int mode);
    case (mode)
      0: return $signed(24'($urandom));
      1: return $urandom_range(0, 1) ? ValMax : ValMin;
      default: return int'($urandom_range(0, 262144)) - 131072;
    endcase
  endfunction

  task automatic send_grid(int rows, int mode);
    int w;
    w = eff_width();
    for (int i = 0; i < rows * w; i++)
      send_point(rand_val(mode), rand_val(mode),
                 i == 0 || $urandom_range(0, 299) == 0);
  endtask

  task automatic test_reset_defaults();
    send_grid(3, 2);
    repeat (20) send_point(rand_val(2), rand_val(2), 1'b0);
  endtask

  task automatic test_directed();
    set_grid(3, 3, 0, 0, 0, 0);
    for (int i = 0; i < 9; i++)
      send_point(i * 1000 - 4000, 3000 - i * 700, i == 0);
    set_grid(0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < 9; i++)
      send_point(i[0] ? ValMax : ValMin, i[1] ? ValMin : ValMax, i == 0);
    // second grid follows without a start mark
    for (int i = 0; i < 6; i++)
      send_point(i[0] ? ValMin : ValMax, i[0] ? ValMax : ValMin, 1'b0);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'hffff_ffff;
      2: return $urandom;
      default: return $urandom_range(0, 1 << 23);
    endcase
  endfunction

  task automatic test_random();
    logic [31:0] w, h;
    int rows;
    while (items_sent < 1850) begin
      case ($urandom_range(0, 9))
        0: w = $urandom_range(0, 2);
        1: w = 64;
        2: w = 127;
        default: w = $urandom_range(3, 16);
      endcase
      case ($urandom_range(0, 7))
        0: h = $urandom_range(0, 2);
        1: h = 8191;
        2: h = 4096;
        default: h = $urandom_range(3, 7);
      endcase
      set_grid(w, h, rand_coef(), rand_coef(), rand_coef(), rand_coef());
      calm = ($urandom_range(0, 4) == 0);
      rows = eff_height() > 8 ? 3 : eff_height() + $urandom_range(0, 1);
      if (eff_width() == MaxW) rows = 3;
      send_grid(rows, $urandom_range(0, 3) == 0 ? 0 : ($urandom_range(0, 6) == 0 ? 1 : 2));
      calm = 0;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    u_in = '0;
    v_in = '0;
    grid_start = 1'b0;
    model_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed();
    test_random();
    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### burgers_2d_stencil_step_top.f
src/bgs_pkg.sv
src/bgs_ram.sv
src/bgs_ctrl.sv
src/bgs_dp.sv
src/burgers_2d_stencil_step_top.sv
src/bgs_chk.sv
test/burgers_2d_stencil_step_top_test.sv
